// ===== src/echonet_lite_meter_property_parser_top_assert.svh =====
// Assertion macros for the meter property parser.
`ifndef ECHONET_LITE_METER_PROPERTY_PARSER_TOP_ASSERT_SVH
`define ECHONET_LITE_METER_PROPERTY_PARSER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define ELMPP_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define ELMPP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ELMPP_ASSERT_IMP(label, clk, rst, ante, cons)
`define ELMPP_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== src/elmpp_pkg.sv =====
`default_nettype none
package elmpp_pkg;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic       frame_end;
   } req_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [31:0]       instant_power;
      logic [31:0]       cumulative_energy;
      logic signed [3:0] energy_exponent;
   } rsp_type;

   typedef enum logic [2:0] {
      PH_HEADER,
      PH_EPC,
      PH_PDC,
      PH_DATA,
      PH_DONE
   } phase_type;

   typedef enum logic [1:0] {
      TGT_SKIP,
      TGT_POWER,
      TGT_ENERGY,
      TGT_UNIT
   } target_type;

   localparam logic [7:0] CODE_POWER  = 8'hE7;
   localparam logic [7:0] CODE_ENERGY = 8'hE0;
   localparam logic [7:0] CODE_UNIT   = 8'hE1;
   localparam logic [3:0] HEADER_LEN  = 4'd11;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_SHORT     = 2'd1;
   localparam logic [1:0] STATUS_TRUNCATED = 2'd2;
   localparam logic [1:0] STATUS_MISSING   = 2'd3;

   localparam logic [2:0] SEEN_POWER  = 3'b001;
   localparam logic [2:0] SEEN_ENERGY = 3'b010;
   localparam logic [2:0] SEEN_UNIT   = 3'b100;
   localparam logic [2:0] SEEN_ALL    = 3'b111;

   function automatic logic signed [3:0] unit_exponent(input logic [7:0] u);
      logic signed [3:0] e;
      e = 4'sd0;
      if (u >= 8'd1 && u <= 8'd4) begin
         e = $signed(4'd0 - u[3:0]);
      end else if (u >= 8'd10 && u <= 8'd13) begin
         e = $signed(u[3:0] - 4'd9);
      end
      return e;
   endfunction

endpackage
`default_nettype wire

// ===== src/echonet_lite_meter_property_parser_top.sv =====
// Parses a received ECHONET Lite response frame, one byte per beat, and
// gives one result beat on the byte marked as the end of the frame: a
// status, the instantaneous power (0xE7), the cumulative energy (0xE0) and
// the power-of-ten exponent taken from the unit property (0xE1). A byte is
// taken in every cycle; each byte passes through an input register and one
// step of the parse logic, and the result is written to the output register
// as the final byte leaves the input register. Only the final byte of a
// frame waits, and only while an earlier result has not yet been taken.
`default_nettype none
`include "echonet_lite_meter_property_parser_top_assert.svh"
module echonet_lite_meter_property_parser_top (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire elmpp_pkg::req_type req_data,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output elmpp_pkg::rsp_type      rsp_data
);
   import elmpp_pkg::*;

   req_type in_ff;
   logic    in_valid_ff, in_valid_in;
   rsp_type rsp_ff;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type result;
   logic    advance;
   logic    rsp_failed, rsp_zeroed, end_blocked;

   assign advance   = in_valid_ff && (!in_ff.frame_end || !rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   elmpp_parser u_parser (
      .clock  (clock),
      .reset  (reset),
      .take   (advance),
      .beat   (in_ff),
      .result (result)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance && in_ff.frame_end) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_ff <= req_data;
      end
      if (advance && in_ff.frame_end) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign rsp_failed  = rsp_valid_ff && rsp_ff.status != STATUS_OK;
   assign rsp_zeroed  = rsp_ff.instant_power == 32'd0 &&
                        rsp_ff.cumulative_energy == 32'd0 &&
                        rsp_ff.energy_exponent == 4'sd0;
   assign end_blocked = in_valid_ff && in_ff.frame_end && rsp_valid_ff;

   `ELMPP_ASSERT_NEXT(a_result_follows_end, clock, reset, advance && in_ff.frame_end, rsp_valid_ff)
   `ELMPP_ASSERT_IMP(a_fail_values_zero, clock, reset, rsp_failed, rsp_zeroed)
   `ELMPP_ASSERT_IMP(a_stall_only_on_end, clock, reset, !req_ready, end_blocked)

endmodule
`default_nettype wire

// ===== src/elmpp_parser.sv =====
`default_nettype none
module elmpp_parser (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              take,
   input  wire elmpp_pkg::req_type beat,
   output elmpp_pkg::rsp_type     result
);
   import elmpp_pkg::*;

   logic [3:0]  header_count_ff, header_count_in, header_count_step;
   phase_type   phase_ff, phase_in, phase_step;
   logic [7:0]  props_left_ff, props_left_in, props_left_step;
   logic [7:0]  prop_code_ff, prop_code_in, prop_code_step;
   logic [7:0]  bytes_left_ff, bytes_left_in, bytes_left_step;
   target_type  target_ff, target_in, target_step;
   logic [2:0]  seen_ff, seen_in, seen_step;
   logic [31:0] power_ff, power_in;
   logic [31:0] energy_ff, energy_in;
   logic [7:0]  unit_ff, unit_in;
   logic [7:0]  b;

   assign b = beat.frame_byte;

   always_comb begin
      header_count_step = header_count_ff;
      phase_step        = phase_ff;
      props_left_step   = props_left_ff;
      prop_code_step    = prop_code_ff;
      bytes_left_step   = bytes_left_ff;
      target_step       = target_ff;
      seen_step         = seen_ff;
      power_in          = power_ff;
      energy_in         = energy_ff;
      unit_in           = unit_ff;
      unique case (phase_ff)
         PH_HEADER: begin
            if (header_count_ff < HEADER_LEN) begin
               header_count_step = header_count_ff + 4'd1;
            end else begin
               props_left_step = b;
               phase_step      = (b != 8'd0) ? PH_EPC : PH_DONE;
            end
         end
         PH_EPC: begin
            prop_code_step  = b;
            props_left_step = props_left_ff - 8'd1;
            phase_step      = PH_PDC;
         end
         PH_PDC: begin
            bytes_left_step = b;
            priority if (prop_code_ff == CODE_POWER && b == 8'd4) begin
               target_step = TGT_POWER;
               seen_step   = seen_ff | SEEN_POWER;
            end else if (prop_code_ff == CODE_ENERGY && b == 8'd4) begin
               target_step = TGT_ENERGY;
               seen_step   = seen_ff | SEEN_ENERGY;
            end else if (prop_code_ff == CODE_UNIT && b == 8'd1) begin
               target_step = TGT_UNIT;
               seen_step   = seen_ff | SEEN_UNIT;
            end else begin
               target_step = TGT_SKIP;
            end
            if (b == 8'd0) begin
               phase_step = (props_left_ff != 8'd0) ? PH_EPC : PH_DONE;
            end else begin
               phase_step = PH_DATA;
            end
         end
         PH_DATA: begin
            unique case (target_ff)
               TGT_POWER:  power_in  = {power_ff[23:0], b};
               TGT_ENERGY: energy_in = {energy_ff[23:0], b};
               TGT_UNIT:   unit_in   = b;
               TGT_SKIP:   ;
               default:    ;
            endcase
            bytes_left_step = bytes_left_ff - 8'd1;
            if (bytes_left_ff == 8'd1) begin
               phase_step = (props_left_ff != 8'd0) ? PH_EPC : PH_DONE;
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      if (beat.frame_end) begin
         header_count_in = 4'd0;
         phase_in        = PH_HEADER;
         props_left_in   = 8'd0;
         prop_code_in    = 8'd0;
         bytes_left_in   = 8'd0;
         target_in       = TGT_SKIP;
         seen_in         = 3'd0;
      end else begin
         header_count_in = header_count_step;
         phase_in        = phase_step;
         props_left_in   = props_left_step;
         prop_code_in    = prop_code_step;
         bytes_left_in   = bytes_left_step;
         target_in       = target_step;
         seen_in         = seen_step;
      end
   end

   always_comb begin
      result = '0;
      if (phase_step == PH_HEADER) begin
         result.status = STATUS_SHORT;
      end else if (phase_step == PH_EPC || phase_step == PH_PDC) begin
         result.status = STATUS_TRUNCATED;
      end else if (phase_step == PH_DATA &&
                   (target_step != TGT_SKIP || props_left_step != 8'd0)) begin
         result.status = STATUS_TRUNCATED;
      end else if (seen_step != SEEN_ALL) begin
         result.status = STATUS_MISSING;
      end else begin
         result.status            = STATUS_OK;
         result.instant_power     = power_in;
         result.cumulative_energy = energy_in;
         result.energy_exponent   = unit_exponent(unit_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_count_ff <= 4'd0;
         phase_ff        <= PH_HEADER;
         props_left_ff   <= 8'd0;
         prop_code_ff    <= 8'd0;
         bytes_left_ff   <= 8'd0;
         target_ff       <= TGT_SKIP;
         seen_ff         <= 3'd0;
      end else if (take) begin
         header_count_ff <= header_count_in;
         phase_ff        <= phase_in;
         props_left_ff   <= props_left_in;
         prop_code_ff    <= prop_code_in;
         bytes_left_ff   <= bytes_left_in;
         target_ff       <= target_in;
         seen_ff         <= seen_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         power_ff  <= power_in;
         energy_ff <= energy_in;
         unit_ff   <= unit_in;
      end
   end

endmodule
`default_nettype wire

// ===== tb/echonet_lite_meter_property_parser_monitor.sv =====
`timescale 1ns / 100ps
module echonet_lite_meter_property_parser_monitor (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   input  wire logic               req_ready,
   input  wire elmpp_pkg::req_type req_data,
   input  wire logic               rsp_valid,
   input  wire logic               rsp_ready,
   input  wire elmpp_pkg::rsp_type rsp_data,
   output int                      fail_count,
   output int                      results_pending,
   output logic [3:0][15:0]        status_tally
);
   import elmpp_pkg::*;

   logic [3:0]  hdr_seen;
   phase_type   phase;
   logic [7:0]  props_remaining;
   logic [7:0]  epc;
   logic [7:0]  data_remaining;
   target_type  target;
   logic [31:0] power_word;
   logic [31:0] energy_word;
   logic [7:0]  unit_byte;
   logic [2:0]  captured;

   rsp_type awaited_results[$];

   function automatic logic signed [3:0] exponent_of(input logic [7:0] unit_value);
      int u;
      u = unit_value;
      if (u >= 1 && u <= 4) begin
         return 4'(-u);
      end
      if (u >= 10 && u <= 13) begin
         return 4'(u - 9);
      end
      return 4'sd0;
   endfunction

   function automatic phase_type phase_after_property();
      return (props_remaining != 8'd0) ? PH_EPC : PH_DONE;
   endfunction

   function automatic void clear_frame();
      hdr_seen = '0;
      phase = PH_HEADER;
      props_remaining = '0;
      epc = '0;
      data_remaining = '0;
      target = TGT_SKIP;
      power_word = '0;
      energy_word = '0;
      unit_byte = '0;
      captured = '0;
   endfunction

   function automatic void absorb_byte(input req_type beat);
      rsp_type    outcome;
      logic [1:0] verdict;
      case (phase)
         PH_HEADER: begin
            if (hdr_seen < HEADER_LEN) begin
               hdr_seen = hdr_seen + 4'd1;
            end else begin
               props_remaining = beat.frame_byte;
               phase = phase_after_property();
            end
         end
         PH_EPC: begin
            epc = beat.frame_byte;
            props_remaining = props_remaining - 8'd1;
            phase = PH_PDC;
         end
         PH_PDC: begin
            data_remaining = beat.frame_byte;
            if (epc == CODE_POWER && beat.frame_byte == 8'd4) begin
               target = TGT_POWER;
               captured = captured | SEEN_POWER;
            end else if (epc == CODE_ENERGY && beat.frame_byte == 8'd4) begin
               target = TGT_ENERGY;
               captured = captured | SEEN_ENERGY;
            end else if (epc == CODE_UNIT && beat.frame_byte == 8'd1) begin
               target = TGT_UNIT;
               captured = captured | SEEN_UNIT;
            end else begin
               target = TGT_SKIP;
            end
            phase = (beat.frame_byte == 8'd0) ? phase_after_property() : PH_DATA;
         end
         PH_DATA: begin
            case (target)
               TGT_POWER:  power_word = {power_word[23:0], beat.frame_byte};
               TGT_ENERGY: energy_word = {energy_word[23:0], beat.frame_byte};
               TGT_UNIT:   unit_byte = beat.frame_byte;
               default:    ;
            endcase
            data_remaining = data_remaining - 8'd1;
            if (data_remaining == 8'd0) begin
               phase = phase_after_property();
            end
         end
         default: ;
      endcase

      if (beat.frame_end) begin
         if (phase == PH_HEADER) begin
            verdict = STATUS_SHORT;
         end else if (phase == PH_EPC || phase == PH_PDC) begin
            verdict = STATUS_TRUNCATED;
         end else if (phase == PH_DATA && (target != TGT_SKIP || props_remaining != 8'd0)) begin
            verdict = STATUS_TRUNCATED;
         end else if (captured == SEEN_ALL) begin
            verdict = STATUS_OK;
         end else begin
            verdict = STATUS_MISSING;
         end
         outcome = '0;
         outcome.status = verdict;
         if (verdict == STATUS_OK) begin
            outcome.instant_power = power_word;
            outcome.cumulative_energy = energy_word;
            outcome.energy_exponent = exponent_of(unit_byte);
         end
         awaited_results = {awaited_results, outcome};
         clear_frame();
      end
   endfunction

   function automatic void match_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
         fail_count++;
      end
   endfunction

   function automatic void check_result(input rsp_type got);
      rsp_type want;
      if (awaited_results.size() == 0) begin
         $error("result beat with no frame end awaiting it: status %0d", got.status);
         fail_count++;
         return;
      end
      want = awaited_results.pop_front();
      status_tally[want.status] = status_tally[want.status] + 16'd1;
      match_field("status", 32'(want.status), 32'(got.status));
      match_field("instant_power", want.instant_power, got.instant_power);
      match_field("cumulative_energy", want.cumulative_energy, got.cumulative_energy);
      match_field("energy_exponent", 32'($unsigned(want.energy_exponent)),
                  32'($unsigned(got.energy_exponent)));
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         clear_frame();
         awaited_results.delete();
         fail_count = 0;
         status_tally = '0;
      end else begin
         if (req_valid && req_ready) begin
            absorb_byte(req_data);
         end
         if (rsp_valid && rsp_ready) begin
            check_result(rsp_data);
         end
      end
      results_pending = awaited_results.size();
   end

endmodule

// ===== tb/echonet_lite_meter_property_parser_top_tb.sv =====
`timescale 1ns / 100ps
module echonet_lite_meter_property_parser_top_tb;
   import elmpp_pkg::*;

   localparam int RANDOM_BYTES = 1100;
   localparam int HOLD_CYCLES  = 300;
   localparam int QUIET_LIMIT  = 4000;
   localparam int DRAIN_CYCLES = 8;

   typedef enum int {FRAME_GOOD, FRAME_CUT, FRAME_NOISE} frame_kind_type;
   typedef enum int {PICK_POWER, PICK_ENERGY, PICK_UNIT, PICK_MISFIT, PICK_OTHER} pick_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   int               fail_count;
   int               results_pending;
   logic [3:0][15:0] status_tally;

   int             send_idle = 0;
   int             recv_idle = 0;
   logic           hold_request = 1'b0;
   int             bytes_sent = 0;
   int             frames_sent = 0;
   int             random_start;
   int             roll;
   frame_kind_type kind;
   logic [7:0]     frame_bytes[$];

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   echonet_lite_meter_property_parser_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   echonet_lite_meter_property_parser_monitor frame_monitor (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data        (req_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_data        (rsp_data),
      .fail_count      (fail_count),
      .results_pending (results_pending),
      .status_tally    (status_tally)
   );

   task automatic send_beat(input logic [7:0] value, input logic last);
      int gap;
      gap = 0;
      while (gap < 40 && $urandom_range(99) < send_idle) begin
         gap++;
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{frame_byte: value, frame_end: last};
      @(posedge clock);
      while (req_ready !== 1'b1) begin
         @(posedge clock);
      end
      bytes_sent++;
   endtask

   task automatic send_frame();
      for (int i = 0; i < frame_bytes.size(); i++) begin
         send_beat(frame_bytes[i], i == frame_bytes.size() - 1);
      end
      frames_sent++;
   endtask

   function automatic void push_property(input logic [7:0] code, input logic [7:0] len);
      frame_bytes = {frame_bytes, code, len};
      repeat (len) frame_bytes = {frame_bytes, 8'($urandom_range(255))};
   endfunction

   function automatic void build_frame(input frame_kind_type frame_kind);
      pick_type   picks[$];
      pick_type   held;
      int         j;
      int         keep;
      logic [7:0] code;
      frame_bytes.delete();
      if (frame_kind == FRAME_NOISE) begin
         repeat ($urandom_range(1, 30)) frame_bytes = {frame_bytes, 8'($urandom_range(255))};
         return;
      end
      repeat (11) frame_bytes = {frame_bytes, 8'($urandom_range(255))};
      if ($urandom_range(9) != 0) begin
         if ($urandom_range(9) != 0) picks = {picks, PICK_POWER};
         if ($urandom_range(9) != 0) picks = {picks, PICK_ENERGY};
         if ($urandom_range(9) != 0) picks = {picks, PICK_UNIT};
         repeat ($urandom_range(3)) begin
            picks = {picks, $urandom_range(1) ? PICK_MISFIT : PICK_OTHER};
         end
         if ($urandom_range(4) == 0) picks = {picks, pick_type'($urandom_range(2))};
      end
      for (int i = picks.size() - 1; i > 0; i--) begin
         j = $urandom_range(i);
         held = picks[i];
         picks[i] = picks[j];
         picks[j] = held;
      end
      frame_bytes = {frame_bytes, 8'(picks.size())};
      foreach (picks[i]) begin
         case (picks[i])
            PICK_POWER:  push_property(CODE_POWER, 8'd4);
            PICK_ENERGY: push_property(CODE_ENERGY, 8'd4);
            PICK_UNIT: begin
               frame_bytes = {frame_bytes, CODE_UNIT, 8'd1};
               frame_bytes = {frame_bytes, $urandom_range(3) != 0 ? 8'($urandom_range(15))
                                                                  : 8'($urandom_range(255))};
            end
            PICK_MISFIT: begin
               code = ($urandom_range(2) == 0) ? CODE_POWER
                    : ($urandom_range(1) == 0) ? CODE_ENERGY : CODE_UNIT;
               push_property(code, 8'($urandom_range(6)));
            end
            default: push_property(8'($urandom_range(255)), 8'($urandom_range(5)));
         endcase
      end
      if ($urandom_range(4) == 0) begin
         repeat ($urandom_range(1, 3)) frame_bytes = {frame_bytes, 8'($urandom_range(255))};
      end
      if (frame_kind == FRAME_CUT) begin
         keep = $urandom_range(1, frame_bytes.size());
         frame_bytes = frame_bytes[0:keep-1];
      end
   endfunction

   // A long hold-off lets results back up until the block refuses the final beat of a frame.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_request) begin
            rsp_ready <= 1'b0;
            hold_request <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle);
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("echonet_lite_meter_property_parser_top regression: fail");
      $finish;
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      frame_bytes = '{8'h00};
      send_frame();
      frame_bytes = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                      8'hFF, 8'hFF, 8'd3,
                      CODE_POWER, 8'd4, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                      CODE_ENERGY, 8'd4, 8'h00, 8'h00, 8'h00, 8'h00,
                      CODE_UNIT, 8'd1, 8'd13};
      send_frame();

      random_start = bytes_sent;
      for (int p = 0; p < 3; p++) begin
         send_idle = (p == 0) ? 9 : (p == 1) ? 63 : 0;
         recv_idle = (p == 0) ? 63 : (p == 1) ? 9 : 0;
         if (p == 2) begin
            hold_request <= 1'b1;
            repeat (6) begin
               frame_bytes = '{8'($urandom_range(255))};
               send_frame();
            end
         end
         while (bytes_sent - random_start < (p + 1) * RANDOM_BYTES / 3) begin
            roll = $urandom_range(9);
            kind = (roll < 7) ? FRAME_GOOD : (roll < 9) ? FRAME_CUT : FRAME_NOISE;
            build_frame(kind);
            send_frame();
         end
      end
      req_valid <= 1'b0;

      @(posedge clock);
      while (results_pending != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d bytes in %0d frames under three idling mixes and one long stall.",
               bytes_sent, frames_sent);
      $display("Results checked: %0d ok, %0d short, %0d truncated, %0d missing property.",
               status_tally[STATUS_OK], status_tally[STATUS_SHORT],
               status_tally[STATUS_TRUNCATED], status_tally[STATUS_MISSING]);
      if (fail_count == 0) begin
         $display("echonet_lite_meter_property_parser_top regression: pass");
      end else begin
         $display("echonet_lite_meter_property_parser_top regression: fail");
      end
      $finish;
   end

endmodule
